// ----- rtl/core/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, muted while reset is high
`define FRST_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define FRST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/frst_pkg.sv -----
`timescale 1ns / 1ps

package frst_pkg;

   localparam int IDX_W  = 11;
   localparam int DATA_W = 32;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic              is_query;
      logic              bad;
      logic [IDX_W-1:0]  pos_a;
      logic [IDX_W-1:0]  pos_b;
      logic [DATA_W-1:0] delta;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_QHI,
      ST_QLO,
      ST_DONE
   } back_state_type;

   typedef enum logic [1:0] {
      PK_ADD,
      PK_SUB,
      PK_UPD
   } pend_kind_type;

endpackage

// ----- rtl/core/frst_ram.sv -----
`timescale 1ns / 1ps

module frst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/frst_front.sv -----
`timescale 1ns / 1ps

module frst_front #(
   parameter int SIZE = 1024
) (
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_op,
   input  logic [frst_pkg::IDX_W-1:0]  req_lo_index,
   input  logic [frst_pkg::IDX_W-1:0]  req_hi_index,
   input  logic [frst_pkg::DATA_W-1:0] req_delta,
   input  logic                        clearing,
   output logic                        push_valid,
   input  logic                        push_ready,
   output frst_pkg::cmd_type           push_cmd
);
   import frst_pkg::*;

   localparam int CW = ($clog2(SIZE + 1) > IDX_W) ? $clog2(SIZE + 1) : IDX_W;
   localparam logic [CW-1:0] SIZE_C = CW'(SIZE);

   logic lo_bad;
   logic hi_bad;
   logic query;
   logic bad;

   always_comb begin
      query  = (req_op == OP_QUERY);
      lo_bad = (req_lo_index == '0) || (CW'(req_lo_index) > SIZE_C);
      hi_bad = (req_hi_index == '0) || (CW'(req_hi_index) > SIZE_C)
               || (req_lo_index > req_hi_index);
      bad    = query ? (lo_bad || hi_bad) : lo_bad;
   end

   // a bad update is dropped here and never reaches the queue
   assign req_ready  = !clearing && (push_ready || (!query && bad));
   assign push_valid = req_valid && !clearing && !(!query && bad);

   always_comb begin
      push_cmd.is_query = query;
      push_cmd.bad      = bad;
      push_cmd.pos_a    = query ? req_hi_index : req_lo_index;
      push_cmd.pos_b    = req_lo_index - IDX_W'(1);
      push_cmd.delta    = req_delta;
   end

endmodule

// ----- rtl/core/frst_queue.sv -----
`timescale 1ns / 1ps

module frst_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  frst_pkg::cmd_type in_cmd,
   output logic              out_valid,
   input  logic              out_ready,
   output frst_pkg::cmd_type out_cmd
);
   import frst_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_cmd   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

// ----- rtl/core/frst_back.sv -----
`timescale 1ns / 1ps

module frst_back #(
   parameter int SIZE = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_valid,
   output logic                        cmd_ready,
   input  frst_pkg::cmd_type           cmd,
   output logic                        clearing,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [frst_pkg::DATA_W-1:0] rsp_range_sum,
   output logic                        rsp_bad_index
);
   import frst_pkg::*;

   localparam int AW = (SIZE > 1) ? $clog2(SIZE) : 1;
   localparam int PW = (($clog2(SIZE + 1) > IDX_W) ? $clog2(SIZE + 1) : IDX_W) + 1;
   localparam logic [PW-1:0] SIZE_P = PW'(SIZE);
   localparam logic [AW-1:0] LAST_A = AW'(SIZE - 1);

   back_state_type    state_ff, state_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic [PW-1:0]     lo_pos_ff, lo_pos_in;
   logic [DATA_W-1:0] delta_ff, delta_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic              bad_ff, bad_in;
   logic              pend_ff, pend_in;
   pend_kind_type     pend_kind_ff, pend_kind_in;
   logic [AW-1:0]     pend_addr_ff, pend_addr_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic              rsp_bad_ff, rsp_bad_in;

   logic [PW-1:0]     pos_m1;
   logic [PW-1:0]     low_bit;
   logic [AW-1:0]     rd_addr;
   logic [DATA_W-1:0] rd_data;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic              rsp_free;

   assign pos_m1   = pos_ff - PW'(1);
   assign low_bit  = pos_ff & (~pos_ff + PW'(1));
   assign rd_addr  = pos_m1[AW-1:0];
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   frst_ram #(
      .WIDTH (DATA_W),
      .DEPTH (SIZE)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == LAST_A) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               priority if (!cmd.is_query) begin
                  state_in = ST_UPDATE;
               end else if (cmd.bad) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_QHI;
               end
            end
         end
         ST_UPDATE: begin
            if (pos_ff > SIZE_P) begin
               state_in = ST_IDLE;
            end
         end
         ST_QHI: begin
            if (pos_ff == '0) begin
               state_in = ST_QLO;
            end
         end
         ST_QLO: begin
            if (pos_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // datapath and outputs
   always_comb begin
      pos_in       = pos_ff;
      lo_pos_in    = lo_pos_ff;
      delta_in     = delta_ff;
      acc_in       = acc_ff;
      bad_in       = bad_ff;
      pend_in      = 1'b0;
      pend_kind_in = pend_kind_ff;
      pend_addr_in = pend_addr_ff;
      clr_addr_in  = clr_addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_sum_in   = rsp_sum_ff;
      rsp_bad_in   = rsp_bad_ff;
      wr_en        = 1'b0;
      wr_addr      = pend_addr_ff;
      wr_data      = rd_data + delta_ff;
      cmd_ready    = 1'b0;

      // read data from the previous cycle
      if (pend_ff) begin
         unique case (pend_kind_ff)
            PK_ADD:  acc_in = acc_ff + rd_data;
            PK_SUB:  acc_in = acc_ff - rd_data;
            PK_UPD:  wr_en  = 1'b1;
            default: acc_in = acc_ff;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = '0;
            clr_addr_in = clr_addr_ff + AW'(1);
         end
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               pos_in    = PW'(cmd.pos_a);
               lo_pos_in = PW'(cmd.pos_b);
               delta_in  = cmd.delta;
               acc_in    = '0;
               bad_in    = cmd.bad;
            end
         end
         ST_UPDATE: begin
            if (pos_ff <= SIZE_P) begin
               pend_in      = 1'b1;
               pend_kind_in = PK_UPD;
               pend_addr_in = rd_addr;
               pos_in       = pos_ff + low_bit;
            end
         end
         ST_QHI: begin
            if (pos_ff != '0) begin
               pend_in      = 1'b1;
               pend_kind_in = PK_ADD;
               pos_in       = pos_ff - low_bit;
            end else begin
               pos_in = lo_pos_ff;
            end
         end
         ST_QLO: begin
            if (pos_ff != '0) begin
               pend_in      = 1'b1;
               pend_kind_in = PK_SUB;
               pos_in       = pos_ff - low_bit;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = bad_ff ? '0 : acc_ff;
               rsp_bad_in   = bad_ff;
            end
         end
         default: clr_addr_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         pend_ff      <= 1'b0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff       <= pos_in;
      lo_pos_ff    <= lo_pos_in;
      delta_ff     <= delta_in;
      acc_ff       <= acc_in;
      bad_ff       <= bad_in;
      pend_kind_ff <= pend_kind_in;
      pend_addr_ff <= pend_addr_in;
      rsp_sum_ff   <= rsp_sum_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign clearing      = (state_ff == ST_CLEAR);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_range_sum = rsp_sum_ff;
   assign rsp_bad_index = rsp_bad_ff;

endmodule

// ----- rtl/core/fenwick_range_sum_table_top.sv -----
`timescale 1ns / 1ps

// Range-sum table over SIZE signed 32-bit entries kept as a binary indexed tree
// in one single-port-read RAM. After reset the table is zeroed by a clearing
// pass over every entry, during which req_ready stays low. An update (op 0) adds
// delta at lo_index and gives no response; a query (op 1) responds with the
// wrapped sum over lo_index..hi_index, or bad_index set and a zero sum when an
// index is zero, above SIZE or the range is reversed. Requests are checked on
// entry and parked in a two-deep queue, so new requests are taken while a
// response waits. The engine reads one tree slot per cycle through the RAM's
// registered read port: an update walks the tree upward from lo_index, a query
// walks down from hi_index and then from lo_index - 1, a rejected query goes
// straight to its response without a walk, and a rejected update is dropped on
// entry without reaching the engine.

module fenwick_range_sum_table_top #(
   parameter int SIZE = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_op,
   input  logic [frst_pkg::IDX_W-1:0]         req_lo_index,
   input  logic [frst_pkg::IDX_W-1:0]         req_hi_index,
   input  logic signed [frst_pkg::DATA_W-1:0] req_delta,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [frst_pkg::DATA_W-1:0] rsp_range_sum,
   output logic                               rsp_bad_index
);
   import frst_pkg::*;

   logic    clearing;
   logic    push_valid;
   logic    push_ready;
   cmd_type push_cmd;
   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;

   frst_front #(
      .SIZE (SIZE)
   ) u_front (
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_lo_index (req_lo_index),
      .req_hi_index (req_hi_index),
      .req_delta    (req_delta),
      .clearing     (clearing),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_cmd     (push_cmd)
   );

   frst_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_cmd    (push_cmd),
      .out_valid (cmd_valid),
      .out_ready (cmd_ready),
      .out_cmd   (cmd)
   );

   frst_back #(
      .SIZE (SIZE)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (cmd_valid),
      .cmd_ready     (cmd_ready),
      .cmd           (cmd),
      .clearing      (clearing),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_range_sum (rsp_range_sum),
      .rsp_bad_index (rsp_bad_index)
   );

endmodule

// ----- rtl/core/frst_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module frst_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [frst_pkg::DATA_W-1:0] rsp_range_sum,
   input logic                        rsp_bad_index
);
   import frst_pkg::*;

   `FRST_ASSERT_ALWAYS(a_no_rsp_after_reset, clock, reset |=> !rsp_valid, "response right after reset")

   `FRST_ASSERT_ALWAYS(a_clear_blocks_req, clock, reset |=> !req_ready, "request taken during clear")

   `FRST_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_range_sum) && $stable(rsp_bad_index), "stalled response changed")

   `FRST_ASSERT(a_bad_zero, clock, reset, rsp_valid && rsp_bad_index |-> rsp_range_sum == '0, "rejected query with nonzero sum")

endmodule

bind fenwick_range_sum_table_top frst_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_range_sum (rsp_range_sum),
   .rsp_bad_index (rsp_bad_index)
);
